// ===== hw/rtl/psrl_pkg.sv =====
package psrl_pkg;

   localparam int SOURCE_KEY_WIDTH = 32;
   localparam int COUNT_WIDTH      = 8;
   localparam logic [COUNT_WIDTH-1:0] BUDGET_RESET = 8'd8;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [SOURCE_KEY_WIDTH-1:0] source_key;
      logic                        key_absent;
   } req_type;

   typedef struct packed {
      logic      pass_event;
      count_type source_count;
      logic      table_full;
   } rsp_type;

endpackage

// ===== hw/rtl/psrl_slot_table.sv =====
module psrl_slot_table
   import psrl_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      lookup_en,
   input  req_type   lookup_req,
   input  count_type budget,
   output rsp_type   result
);

   logic [SLOTS-1:0] used_ff;
   logic [KEY_WIDTH:0] key_ff [SLOTS];
   count_type        count_ff [SLOTS];

   logic [KEY_WIDTH-1:0] key_val;
   logic [KEY_WIDTH:0]   key_in;
   count_type            count_in;
   count_type            sel_count;
   logic [SLOTS-1:0]     match_vec;
   logic [SLOTS-1:0]     hit_oh;
   logic [SLOTS-1:0]     free_oh;
   logic [SLOTS-1:0]     wr_oh;
   logic                 hit;
   logic                 claim;
   logic                 full;
   logic                 pass;

   // only the low KEY_WIDTH bits of the source key take part in the match; a shorter source key is zero-extended
   generate
      if (KEY_WIDTH <= SOURCE_KEY_WIDTH) begin : g_trunc
         assign key_val = lookup_req.source_key[KEY_WIDTH-1:0];
      end else begin : g_ext
         assign key_val = {{(KEY_WIDTH-SOURCE_KEY_WIDTH){1'b0}}, lookup_req.source_key};
      end
   endgenerate

   // the absent key has its own marker bit and a zero key field
   assign key_in = lookup_req.key_absent ? {1'b1, {KEY_WIDTH{1'b0}}} : {1'b0, key_val};

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = used_ff[i] && (key_ff[i] == key_in);
      end
   end

   // isolate the lowest set bit of the matches and the lowest clear bit of the used slots
   assign hit_oh  = match_vec & (~match_vec + SLOTS'(1));
   assign free_oh = ~used_ff & (used_ff + SLOTS'(1));
   assign hit     = |match_vec;
   assign claim   = !hit && !(&used_ff);
   assign full    = !hit && (&used_ff);

   always_comb begin
      sel_count = '0;
      for (int i = 0; i < SLOTS; i++) begin
         sel_count = sel_count | (hit_oh[i] ? count_ff[i] : '0);
      end
   end

   always_comb begin
      count_type base;
      base     = hit ? sel_count : '0;
      pass     = !full && (base < budget);
      count_in = pass ? COUNT_WIDTH'(base + 1'b1) : base;
   end

   assign wr_oh = hit ? hit_oh : (claim ? free_oh : '0);

   always_comb begin
      result.pass_event   = pass;
      result.source_count = full ? '0 : count_in;
      result.table_full   = full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (lookup_en && claim) begin
         used_ff <= used_ff | free_oh;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (lookup_en && wr_oh[i]) begin
            key_ff[i]   <= key_in;
            count_ff[i] <= count_in;
         end
      end
   end

endmodule

// ===== hw/rtl/per_source_event_rate_limiter.sv =====
// Pipeline: an accepted request waits in the request register; its result is then
// written to the result register once that register is empty or being taken.
// Throughput: one request per cycle while results are taken; the slot table lookup,
// claim and count update are combinational between the two pipeline registers.
// Reset (synchronous, active high): all slots free, budget = 8,
// both pipeline registers empty.
module per_source_event_rate_limiter
   import psrl_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_payload,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  count_type csr_data
);

   logic      s1_valid_ff;
   req_type   s1_req_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   count_type budget_ff;
   rsp_type   rsp_in;
   logic      advance;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else if (csr_valid) begin
         budget_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_payload;
      end
   end

   psrl_slot_table #(
      .SLOTS     (SLOTS),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_en  (advance),
      .lookup_req (s1_req_ff),
      .budget     (budget_ff),
      .result     (rsp_in)
   );

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sim/tb_per_source_event_rate_limiter.sv =====
module tb_per_source_event_rate_limiter;
   import psrl_pkg::*;

   localparam int SLOT_COUNT       = 16;
   localparam int LONG_HOLD_CYCLES = 80;

   typedef logic [SOURCE_KEY_WIDTH:0] slot_key_type;

   class rate_limit_scoreboard;
      count_type    budget;
      bit           slot_used[SLOT_COUNT];
      slot_key_type slot_key[SLOT_COUNT];
      count_type    slot_count[SLOT_COUNT];
      rsp_type      expected_verdicts[$];
      int           mismatch_count;

      function new();
         budget = BUDGET_RESET;
         mismatch_count = 0;
         foreach (slot_used[i]) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_count[i] = '0;
         end
      endfunction

      function void set_budget(count_type value);
         budget = value;
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      // Look up or claim the slot for this source, then apply the budget.
      function rsp_type count_event(req_type r);
         slot_key_type key;
         int           hit;
         int           open_slot;
         int           s;
         rsp_type      verdict;
         key = r.key_absent ? {1'b1, {SOURCE_KEY_WIDTH{1'b0}}} : {1'b0, r.source_key};
         hit = -1;
         open_slot = -1;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_used[i]) begin
               if (hit < 0 && slot_key[i] == key) hit = i;
            end else if (open_slot < 0) begin
               open_slot = i;
            end
         end
         verdict = '0;
         if (hit >= 0) begin
            s = hit;
         end else if (open_slot >= 0) begin
            s = open_slot;
            slot_used[s]  = 1'b1;
            slot_key[s]   = key;
            slot_count[s] = '0;
         end else begin
            verdict.table_full = 1'b1;
            return verdict;
         end
         if (slot_count[s] < budget) begin
            slot_count[s]      = slot_count[s] + 1'b1;
            verdict.pass_event = 1'b1;
         end
         verdict.source_count = slot_count[s];
         return verdict;
      endfunction

      function void note_request(req_type r);
         expected_verdicts.push_back(count_event(r));
      endfunction

      function void note_mismatch(string field, int unsigned want, int unsigned got);
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_verdicts.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = expected_verdicts.pop_front();
         if (got.pass_event !== want.pass_event)
            note_mismatch("pass_event", 32'(want.pass_event), 32'(got.pass_event));
         if (got.source_count !== want.source_count)
            note_mismatch("source_count", 32'(want.source_count), 32'(got.source_count));
         if (got.table_full !== want.table_full)
            note_mismatch("table_full", 32'(want.table_full), 32'(got.table_full));
      endfunction
   endclass

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   req_type   req_payload;
   logic      rsp_valid;
   logic      rsp_ready;
   rsp_type   rsp_payload;
   logic      csr_valid;
   logic      csr_ready;
   count_type csr_data;

   bit idle_on;
   bit long_hold_request;

   rate_limit_scoreboard sb = new();

   // Sources known to own a slot once the directed part has filled the table.
   slot_key_type key_pool[SLOT_COUNT];

   per_source_event_rate_limiter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("tb_per_source_event_rate_limiter: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
   end

   // Result side: random stall bursts, plus one long hold on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            stall_left = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16);
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic req_type build_request(logic [31:0] source_key, logic key_absent);
      req_type r;
      r.source_key = source_key;
      r.key_absent = key_absent;
      return r;
   endfunction

   // Absent sources get random don't-care key bits.
   function automatic req_type request_for(slot_key_type key);
      if (key[SOURCE_KEY_WIDTH]) return build_request($urandom(), 1'b1);
      return build_request(key[SOURCE_KEY_WIDTH-1:0], 1'b0);
   endfunction

   // Called and returns at a falling edge; leaves valid low after acceptance.
   task automatic send_request(req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clock);
      req_payload = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_for_drain();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_budget(count_type value);
      wait_for_drain();
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_budget(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_traffic(int items, int hot_percent, int fresh_percent, int pause_at,
                              int quiet_tail);
      int           roll;
      slot_key_type key;
      for (int n = 0; n < items; n++) begin
         if (n == pause_at) wait_for_drain();
         if (n == items - quiet_tail) idle_on = 1'b0;
         roll = $urandom_range(0, 99);
         if (roll < hot_percent) key = key_pool[1];
         else if (roll < hot_percent + fresh_percent) key = {1'b0, $urandom()};
         else key = key_pool[$urandom_range(0, SLOT_COUNT - 1)];
         send_request(request_for(key));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      idle_on = 1'b1;
      long_hold_request = 1'b0;
      key_pool[0] = {1'b1, 32'h0};
      key_pool[1] = {1'b0, 32'h0};
      key_pool[2] = {1'b0, 32'hFFFF_FFFF};
      key_pool[3] = {1'b0, 32'h8000_0001};
      for (int k = 0; k < SLOT_COUNT - 4; k++) key_pool[4 + k] = {1'b0, 32'h1 << k};
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Absent source is distinct from key zero and ignores its key bits.
      send_request(build_request(32'h0, 1'b1));
      send_request(build_request(32'h0, 1'b0));
      send_request(build_request(32'hFFFF_FFFF, 1'b1));
      send_request(build_request(32'hFFFF_FFFF, 1'b0));
      // Run key zero past the reset budget.
      repeat (8) send_request(build_request(32'h0, 1'b0));

      // Zero budget: new source still claims a slot, existing counts hold.
      write_budget(8'd0);
      send_request(build_request(32'h8000_0001, 1'b0));
      send_request(build_request(32'h0, 1'b0));
      send_request(build_request(32'h1234_5678, 1'b1));

      // Fill the table, then overflow it.
      write_budget(8'd255);
      for (int k = 4; k < SLOT_COUNT; k++) send_request(request_for(key_pool[k]));
      send_request(build_request(32'h7FFF_FFFE, 1'b0));
      send_request(build_request($urandom(), 1'b1));

      run_traffic(350, 0, 15, -1, 0);
      // Hammer one source up to the count ceiling without gaps.
      idle_on = 1'b0;
      run_traffic(300, 90, 3, -1, 0);
      idle_on = 1'b1;

      write_budget(count_type'($urandom_range(1, 254)));
      long_hold_request = 1'b1;
      run_traffic(350, 10, 15, 175, 0);

      write_budget(8'd1);
      run_traffic(300, 5, 15, -1, 0);

      write_budget(8'd255);
      run_traffic(400, 10, 10, -1, 200);

      wait_for_drain();
      repeat (8) @(negedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("tb_per_source_event_rate_limiter: PASS");
      end else begin
         $display("tb_per_source_event_rate_limiter: FAIL");
      end
      $finish;
   end

endmodule
